/* rtl/pric_pkg.sv */
// ----------------------------------------------------------------------------
// pric_pkg
// Shared types and constants for the permutation rank isomorphism check.
// ----------------------------------------------------------------------------
package pric_pkg;

    // Matrix size and derived widths.
    localparam int MAX_VERTICES = 8;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 2);
    localparam int RANK_W       = 16;
    localparam int BITCNT_W     = $clog2(RANK_W);

    // Input opcodes as they arrive on tuser.
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    // Command kinds carried through the queue.
    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_TEST   = 2'd2
    } cmd_kind_t;

    // One queued command.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    column;
        logic                edge_bit;
        logic [RANK_W-1:0]   rank;
    } cmd_t;

endpackage

/* rtl/permutation_rank_isomorphism_check.sv */
// ----------------------------------------------------------------------------
// permutation_rank_isomorphism_check
// Loads two adjacency matrices and tests permutation ranks for isomorphism.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         tuser[1:0] opcode; tdata row, column, edge_bit, rank
// m_*       out        tdata[0] is_match, tdata[1] found_any (one per test)
// cfg_*     in         vertex_count, written when cfg_we is high
//
// A load is written in the back end as it is taken from the queue. A test
// runs the sequencer through digit division, permutation build and compare;
// the bit-serial divider takes most of its time.
// Reset clears control state, the found flag and sets vertex_count to 8.
// A two-entry queue lets inputs arrive while a test runs; a held result
// stalls only the finish of the next test.
// ----------------------------------------------------------------------------
module permutation_rank_isomorphism_check
    import pric_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic [23:0] s_tdata,   // [2:0] row, [5:3] column, [6] edge_bit, [22:7] rank
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] is_match, [1] found_any
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);

    logic       q_valid;
    logic       q_ready;
    cmd_t       q_cmd;
    logic [3:0] vertex_count_reg;

    // Vertex count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= 4'd8;
        else if (cfg_we)
            vertex_count_reg <= cfg_wdata;
    end

    pric_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    pric_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_count (vertex_count_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

/* rtl/pric_front.sv */
// ----------------------------------------------------------------------------
// pric_front
// Accepts input beats, classifies the opcode and queues commands (2 deep).
// ----------------------------------------------------------------------------
module pric_front
    import pric_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic [23:0] s_tdata,   // [2:0] row, [5:3] column, [6] edge_bit, [22:7] rank
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    cmd_t       mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic       push, pop, keep;
    cmd_t       in_cmd;

    // Classify the incoming beat; undefined opcodes are accepted and dropped.
    always_comb
    begin
        in_cmd.row      = s_tdata[2:0];
        in_cmd.column   = s_tdata[5:3];
        in_cmd.edge_bit = s_tdata[6];
        in_cmd.rank     = s_tdata[22:7];
        keep            = 1'b1;
        case (s_tuser)
            OP_LOAD_A: in_cmd.kind = CMD_LOAD_A;
            OP_LOAD_B: in_cmd.kind = CMD_LOAD_B;
            OP_TEST:   in_cmd.kind = CMD_TEST;
            default:
            begin
                in_cmd.kind = CMD_TEST;
                keep        = 1'b0;
            end
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = q_valid && q_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/pric_back.sv */
// ----------------------------------------------------------------------------
// pric_back
// Executes queued commands: matrix loads, and rank tests through a sequencer
// of digit division, permutation build and row-by-row compare.
// ----------------------------------------------------------------------------
module pric_back
    import pric_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [3:0]       vertex_count,
    input  logic             q_valid,
    output logic             q_ready,
    input  cmd_t             q_cmd,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata   // [0] is_match, [1] found_any
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PLACE = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_PERM  = 5'b01000,
        ST_CMP   = 5'b10000
    } state_t;

    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_VERTICES);

    state_t                state_reg, state_next;
    logic [MAX_VERTICES-1:0] a_rows_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] b_rows_reg [MAX_VERTICES];
    logic [IDX_W-1:0]      digit_reg [MAX_VERTICES];
    logic [IDX_W-1:0]      perm_reg  [MAX_VERTICES];
    logic [IDX_W-1:0]      perm_next [MAX_VERTICES];
    logic [RANK_W-1:0]     r_reg;
    logic [CNT_W-1:0]      pl_reg;
    logic [CNT_W-1:0]      i_reg;
    logic [3:0]            pr_reg;
    logic [BITCNT_W-1:0]   bit_reg;
    logic                  match_reg;
    logic                  out_valid_reg;
    logic                  out_match_reg;
    logic                  found_reg;

    logic [CNT_W-1:0]      n;
    logic [4:0]            trial;
    logic                  ge;
    logic [4:0]            prn;
    logic [CNT_W-1:0]      idx_raw, idx;
    logic [IDX_W-1:0]      pick;
    logic [MAX_VERTICES-1:0] brow;
    logic                  mismatch;
    logic                  out_free;

    // Vertex count saturated to the matrix size.
    assign n = (CNT_W'(vertex_count) > N_MAX) ? N_MAX : CNT_W'(vertex_count);

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, found_reg, out_match_reg};

    // One restoring division step by the current place value.
    always_comb
    begin
        trial = {pr_reg, r_reg[RANK_W-1]};
        ge    = (trial >= {1'b0, pl_reg});
        prn   = ge ? (trial - {1'b0, pl_reg}) : trial;
    end

    // One permutation step: move the selected element forward to position i.
    always_comb
    begin
        idx_raw = i_reg + CNT_W'(digit_reg[i_reg[IDX_W-1:0]]);
        idx     = (idx_raw >= n) ? (n - 1'b1) : idx_raw;
        pick    = perm_reg[idx[IDX_W-1:0]];
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            if (CNT_W'(k) == i_reg)
                perm_next[k] = pick;
            else if (CNT_W'(k) > i_reg && CNT_W'(k) <= idx && k > 0)
                perm_next[k] = perm_reg[k-1];
            else
                perm_next[k] = perm_reg[k];
        end
    end

    // Row compare of A against the permuted row of B.
    always_comb
    begin
        brow     = b_rows_reg[perm_reg[i_reg[IDX_W-1:0]]];
        mismatch = 1'b0;
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            if (CNT_W'(j) < n &&
                a_rows_reg[i_reg[IDX_W-1:0]][j] != brow[perm_reg[j]])
                mismatch = 1'b1;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid && q_cmd.kind == CMD_TEST)
                    state_next = ST_PLACE;
            ST_PLACE:
                if (pl_reg > n || r_reg == '0)
                    state_next = ST_PERM;
                else
                    state_next = ST_DIV;
            ST_DIV:
                if (bit_reg == BITCNT_W'(RANK_W - 1))
                    state_next = ST_PLACE;
            ST_PERM:
                if (i_reg >= n)
                    state_next = ST_CMP;
            ST_CMP:
                if (i_reg >= n && out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CMP && i_reg >= n && out_free)
            begin
                out_valid_reg <= 1'b1;
                found_reg     <= found_reg | match_reg;
            end
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        CMD_LOAD_A: a_rows_reg[q_cmd.row][q_cmd.column] <= q_cmd.edge_bit;
                        CMD_LOAD_B: b_rows_reg[q_cmd.row][q_cmd.column] <= q_cmd.edge_bit;
                        default:
                        begin
                            r_reg     <= q_cmd.rank;
                            pl_reg    <= CNT_W'(1);
                            pr_reg    <= 4'd0;
                            match_reg <= 1'b1;
                            for (int k = 0; k < MAX_VERTICES; k++)
                            begin
                                digit_reg[k] <= '0;
                                perm_reg[k]  <= IDX_W'(k);
                            end
                        end
                    endcase
                end
            end
            ST_PLACE:
            begin
                bit_reg <= '0;
                pr_reg  <= 4'd0;
                i_reg   <= '0;
            end
            ST_DIV:
            begin
                r_reg   <= {r_reg[RANK_W-2:0], ge};
                pr_reg  <= prn[3:0];
                bit_reg <= bit_reg + 1'b1;
                if (bit_reg == BITCNT_W'(RANK_W - 1))
                begin
                    digit_reg[IDX_W'(n - pl_reg)] <= prn[IDX_W-1:0];
                    pl_reg <= pl_reg + 1'b1;
                end
            end
            ST_PERM:
            begin
                if (i_reg >= n)
                    i_reg <= '0;
                else
                begin
                    perm_reg <= perm_next;
                    i_reg    <= i_reg + 1'b1;
                end
            end
            ST_CMP:
            begin
                if (i_reg < n)
                begin
                    match_reg <= match_reg & !mismatch;
                    i_reg     <= i_reg + 1'b1;
                end
                else if (out_free)
                    out_match_reg <= match_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Commands are taken from the queue only while the sequencer is idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == ST_IDLE)
        else $error("queue popped while busy");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, pr_reg} < {1'b0, pl_reg})
        else $error("division remainder out of range");

    // The permutation index never passes the vertex count.
    a_perm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PERM |-> i_reg <= n)
        else $error("permutation index out of range");

    // The found flag is sticky.
    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(found_reg))
        else $error("found flag cleared");

endmodule

/* tb/permutation_rank_isomorphism_check_tb.sv */
// ----------------------------------------------------------------------------
// permutation_rank_isomorphism_check_tb
// Self-checking testbench for the permutation rank isomorphism check. Matrix
// loads and rank tests stream in under random idling; a local model of both
// matrices, the vertex count and the found flag predicts each result beat.
// ----------------------------------------------------------------------------
module permutation_rank_isomorphism_check_tb;
    import pric_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int         SETTLE     = 400;
    localparam int         CYCLE_CAP  = 800000;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  row;
        logic [2:0]  column;
        logic        edge_bit;
        logic [15:0] rank;
    } beat_t;

    typedef struct {
        logic is_match;
        logic found_any;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;

    beat_t       pending_beats[$];
    verdict_t    verdicts_due[$];

    // Local copy of the block state.
    logic [7:0]  graph_a[8];
    logic [7:0]  graph_b[8];
    logic        found_seen;
    logic [3:0]  n_vertices;

    int          fail_count;
    int          tests_sent;
    int          matches_seen;
    int          cycle_count;
    logic        calm;
    logic        long_hold_req;
    logic        long_hold_done;
    int          hold_left;

    permutation_rank_isomorphism_check u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Permutation built from the factoradic digits of a rank.
    typedef int perm_t[8];

    function automatic perm_t unrank(input logic [15:0] rank, input int n);
        perm_t       perm;
        int          digit[8];
        longint      divisor;
        longint      q;
        int          idx;
        int          pick;
        divisor = 1;
        for (int k = 0; k < 8; k++)
        begin
            digit[k] = 0;
            perm[k]  = k;
        end
        for (int place = 1; place <= n; place++)
        begin
            q = longint'(rank) / divisor;
            if (q == 0)
                break;
            digit[n - place] = int'(q % place);
            divisor = divisor * place;
        end
        for (int i = 0; i < n; i++)
        begin
            idx = i + digit[i];
            if (idx >= n)
                idx = n - 1;
            pick = perm[idx];
            for (int j = idx; j > i; j--)
                perm[j] = perm[j - 1];
            perm[i] = pick;
        end
        return perm;
    endfunction

    function automatic int eff_vertices();
        return (n_vertices > 8) ? 8 : int'(n_vertices);
    endfunction

    function automatic logic ranks_match(input logic [15:0] rank);
        perm_t perm;
        int    n;
        n    = eff_vertices();
        perm = unrank(rank, n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (graph_a[i][j] != graph_b[perm[i]][perm[j]])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted beat to the local state.
    task automatic absorb_beat(input beat_t b);
        verdict_t v;
        case (b.op)
            OP_LOAD_A: graph_a[b.row][b.column] = b.edge_bit;
            OP_LOAD_B: graph_b[b.row][b.column] = b.edge_bit;
            OP_TEST:
            begin
                v.is_match = ranks_match(b.rank);
                if (v.is_match)
                    found_seen = 1'b1;
                v.found_any = found_seen;
                verdicts_due.push_back(v);
            end
            default: ;
        endcase
    endtask

    // Sender: pops pending beats and predicts each one at acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        beat_t b;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                b.op       = s_tuser;
                b.row      = s_tdata[2:0];
                b.column   = s_tdata[5:3];
                b.edge_bit = s_tdata[6];
                b.rank     = s_tdata[22:7];
                absorb_beat(b);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 27))
                begin
                    b = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= b.op;
                    s_tdata  <= {1'b0, b.rank, b.edge_bit, b.column, b.row};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks result beats and throttles m_tready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        int       errs;
        if (!rst_n)
        begin
            m_tready       <= 1'b0;
            fail_count     <= 0;
            matches_seen   <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                errs = 0;
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual %b", $time, m_tdata[1:0]);
                    errs = 1;
                end
                else
                begin
                    v = verdicts_due.pop_front();
                    if (m_tdata[0] !== v.is_match)
                    begin
                        $display("%0t: is_match expected %b actual %b",
                                 $time, v.is_match, m_tdata[0]);
                        errs = errs + 1;
                    end
                    if (m_tdata[1] !== v.found_any)
                    begin
                        $display("%0t: found_any expected %b actual %b",
                                 $time, v.found_any, m_tdata[1]);
                        errs = errs + 1;
                    end
                    if (v.is_match)
                        matches_seen <= matches_seen + 1;
                end
                fail_count <= fail_count + errs;
            end
            // A long hold-off lets the input side back up.
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                hold_left      <= 600;
                m_tready       <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // Run limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == CYCLE_CAP)
            begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         verdicts_due.size());
                $display("permutation_rank_isomorphism_check regression: fail");
                $finish;
            end
        end
    end

    task automatic add_beat(input logic [1:0] op, input int row, input int column,
                            input logic bit_val, input logic [15:0] rank);
        beat_t b;
        b.op       = op;
        b.row      = row[2:0];
        b.column   = column[2:0];
        b.edge_bit = bit_val;
        b.rank     = rank;
        pending_beats.push_back(b);
        if (op == OP_TEST)
            tests_sent++;
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || s_tvalid || verdicts_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [3:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_vertices = value;
    endtask

    // Loads A at random and B as A relabeled by the permutation of one rank.
    task automatic load_isomorphic_pair(input int n, input logic [15:0] rank, input int span);
        perm_t       perm;
        logic [7:0]  a_img[8];
        perm = unrank(rank, n);
        for (int i = 0; i < span; i++)
            for (int j = 0; j < span; j++)
            begin
                a_img[i][j] = 1'($urandom_range(1));
                add_beat(OP_LOAD_A, i, j, a_img[i][j], 16'($urandom_range(65535)));
            end
        for (int i = 0; i < span; i++)
            for (int j = 0; j < span; j++)
                add_beat(OP_LOAD_B, perm[i], perm[j], a_img[i][j],
                         16'($urandom_range(65535)));
    endtask

    function automatic int fact(input int n);
        int f;
        f = 1;
        for (int k = 2; k <= n; k++)
            f = f * k;
        return f;
    endfunction

    // Stimulus and phase control.
    initial
    begin
        logic [3:0]  counts[$];
        logic [15:0] good_rank;
        int          n;
        int          nf;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        tests_sent    = 0;
        found_seen    = 1'b0;
        n_vertices    = 4'd8;
        for (int k = 0; k < 8; k++)
        begin
            graph_a[k] = '0;
            graph_b[k] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the reset count of eight: every entry gets written first.
        good_rank = 16'd40319;
        load_isomorphic_pair(8, good_rank, 8);
        add_beat(OP_TEST, 0, 0, 1'b0, 16'd0);
        add_beat(OP_TEST, 7, 7, 1'b1, 16'hFFFF);
        add_beat(OP_TEST, 0, 0, 1'b0, good_rank);
        add_beat(OP_TEST, 0, 0, 1'b0, 16'd40320);
        add_beat(OP_IGNORED, 7, 7, 1'b1, 16'hFFFF);
        add_beat(OP_IGNORED, 0, 0, 1'b0, 16'd0);
        add_beat(OP_TEST, 0, 0, 1'b0, good_rank);
        add_beat(OP_LOAD_A, 7, 0, 1'b1, 16'd0);
        add_beat(OP_LOAD_A, 7, 0, 1'b0, 16'd0);
        add_beat(OP_TEST, 0, 0, 1'b0, 16'd5040);
        drain();

        // Counts cover the extremes, the empty compare and saturation.
        counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd9, 4'd3, 4'd4,
                   4'd5, 4'd6, 4'd7, 4'd2, 4'd3};
        foreach (counts[p])
        begin
            write_count(counts[p]);
            calm          = (p == 4);
            long_hold_req = (p == 6);
            n  = eff_vertices();
            nf = fact(n);
            good_rank = 16'($urandom_range(nf - 1));
            load_isomorphic_pair(n, good_rank, n);
            for (int t = 0; t < 15; t++)
            begin
                case ($urandom_range(9))
                    0, 1:    add_beat(OP_TEST, $urandom_range(7), $urandom_range(7),
                                      1'($urandom_range(1)), good_rank);
                    2:       add_beat(OP_TEST, 0, 0, 1'b0,
                                      16'(good_rank + nf * $urandom_range(65535 / nf)));
                    3:       add_beat(2'($urandom_range(1)), $urandom_range(7),
                                      $urandom_range(7), 1'($urandom_range(1)),
                                      16'($urandom_range(65535)));
                    4:       add_beat(OP_IGNORED, $urandom_range(7), $urandom_range(7),
                                      1'($urandom_range(1)), 16'($urandom_range(65535)));
                    5:       add_beat(OP_TEST, 0, 0, 1'b0, 16'($urandom_range(nf - 1)));
                    default: add_beat(OP_TEST, $urandom_range(7), $urandom_range(7),
                                      1'($urandom_range(1)), 16'($urandom_range(65535)));
                endcase
            end
            drain();
        end

        $display("Ran %0d rank tests over %0d vertex-count settings; %0d matched.",
                 tests_sent, counts.size() + 1, matches_seen);
        if (fail_count == 0)
            $display("permutation_rank_isomorphism_check regression: pass");
        else
            $display("permutation_rank_isomorphism_check regression: fail");
        $finish;
    end

endmodule
